### rtl/damped_spring_force_breaker_assert.svh
// Assertion macros used by the checker file.
`ifndef DAMPED_SPRING_FORCE_BREAKER_ASSERT_SVH
`define DAMPED_SPRING_FORCE_BREAKER_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define DSF_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define DSF_ASSERT_NXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

### rtl/dsf_pkg.sv
// ----------------------------------------------------------------------------
// dsf_pkg
// Shared types and register indexes of the damped spring force block.
// ----------------------------------------------------------------------------
package dsf_pkg;
    localparam logic [1:0] REG_STIFF = 2'd0;
    localparam logic [1:0] REG_DAMP  = 2'd1;
    localparam logic [1:0] REG_BREAK = 2'd2;
    localparam logic [1:0] AXIS_X    = 2'd0;
    localparam logic [1:0] AXIS_Y    = 2'd1;
    localparam logic [1:0] AXIS_Z    = 2'd2;
    // Unused axis code; such a beat is dropped.
    localparam logic [1:0] AXIS_NONE = 2'd3;

    // Opcodes of the shared serial arithmetic unit.
    typedef enum logic [1:0] {
        OP_MUL  = 2'd0,
        OP_SQRT = 2'd1,
        OP_DIV  = 2'd2
    } dsf_op_t;

    // Start and opcode bundle from sequencer to unit.
    typedef struct packed {
        logic    start;
        dsf_op_t op;
    } dsf_ctl_t;
endpackage

### rtl/damped_spring_force_breaker.sv
// A z beat starts the squares, square root, spring force and break check, then the x result;
// each further result is computed after the one before is taken (no tension term at zero length).
// x and y beats are only stored.
// Throughput is set by the shared bit-serial unit, which runs every multiply, root and divide;
// no new beat is taken while a spring is being computed or a result waits.
// Reset: rst_n clears control state, axis state and registers to their reset values.
// ----------------------------------------------------------------------------
// damped_spring_force_breaker
// Spring force with damping and break flag, computed on a bit-serial unit.
// ----------------------------------------------------------------------------
module damped_spring_force_breaker
    import dsf_pkg::*;
#(
    parameter int VALUE_WIDTH = 32,
    parameter int FRAC_BITS   = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [1:0]                    cfg_index,
    input  logic [VALUE_WIDTH-1:0]        cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    axis,
    input  logic signed [VALUE_WIDTH-1:0] pos_a,
    input  logic signed [VALUE_WIDTH-1:0] pos_b,
    input  logic signed [VALUE_WIDTH-1:0] vel_a,
    input  logic signed [VALUE_WIDTH-1:0] vel_b,
    input  logic [VALUE_WIDTH-1:0]        rest_length,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [1:0]                    out_axis,
    output logic signed [VALUE_WIDTH-1:0] force_a,
    output logic signed [VALUE_WIDTH-1:0] force_b,
    output logic                          overstretched,
    output logic                          zero_length,
    output logic                          last_of_run
);
    localparam int W  = VALUE_WIDTH;
    localparam int AW = 2 * W + 2;
    localparam logic [AW-1:0] VMAX = AW'((64'd1 << (W - 1)) - 1);

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_SQ    = 11'b00000000010,
        S_SQW   = 11'b00000000100,
        S_SQRT  = 11'b00000001000,
        S_FMUL  = 11'b00000010000,
        S_BREAK = 11'b00000100000,
        S_TMUL  = 11'b00001000000,
        S_TDIV  = 11'b00010000000,
        S_DMA   = 11'b00100000000,
        S_DMB   = 11'b01000000000,
        S_OUT   = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;
    logic signed [W:0]   diff_reg [3];
    logic signed [W-1:0] va_reg [3];
    logic signed [W-1:0] vb_reg [3];
    logic signed [W-1:0] stiff_reg, damp_reg;
    logic [W-1:0]        brk_reg, rest_reg;
    logic [1:0]          idx_reg, idx_next;
    logic [AW-1:0]       sum_reg, sum_next;
    // The length can exceed W bits: three squared differences of up to W+1 bits.
    logic [W:0]          len_reg, len_next;
    logic signed [W-1:0] f_reg, f_next;
    logic signed [AW:0]  term_reg, term_next, da_reg, da_next;
    logic                over_reg, over_next;
    logic                pend_reg, pend_next;
    logic signed [W-1:0] fa_reg, fa_next, fb_reg, fb_next;
    dsf_ctl_t            ctl;
    logic [AW-1:0]       opa;
    logic [W:0]          opb;
    logic                u_done;
    logic [AW-1:0]       u_res;
    logic                go_reg;
    logic [W:0]          dmag;
    logic signed [W+1:0] lmr;
    logic [W:0]          lmr_mag;
    logic                fneg, mneg;
    logic [AW-1:0]       shv;
    logic signed [W-1:0] satv;
    logic signed [AW:0]  sa, sb;

    dsf_serial_unit #(.W(W)) u_unit
    (
        .clk  (clk),
        .rst_n(rst_n),
        .ctl  (ctl),
        .opa  (opa),
        .opb  (opb),
        .done (u_done),
        .res  (u_res)
    );

    // Saturate a signed wide value to W bits.
    function automatic logic signed [W-1:0] sat(input logic signed [AW:0] v);
        logic signed [AW:0] mx;
        mx = (AW+1)'(VMAX);
        if (v > mx)
            sat = W'(VMAX);
        else if (v < -mx - 1)
            sat = W'(-mx - 1);
        else
            sat = W'(v);
    endfunction

    assign cfg_ready  = (state_reg == S_IDLE) && !pend_reg;
    assign in_ready   = (state_reg == S_IDLE) && !pend_reg;
    assign out_valid  = pend_reg;
    assign force_a    = fa_reg;
    assign force_b    = fb_reg;
    assign overstretched = over_reg;
    assign zero_length   = (len_reg == '0);
    assign last_of_run   = (out_axis == AXIS_Z);
    assign out_axis   = idx_reg;

    assign dmag    = diff_reg[idx_reg][W] ? -diff_reg[idx_reg] : diff_reg[idx_reg];
    assign lmr     = $signed({1'b0, len_reg}) - $signed({2'b0, rest_reg});
    assign lmr_mag = (W+1)'(lmr[W+1] ? -lmr : lmr);
    assign shv     = u_res >> FRAC_BITS;
    assign satv    = mneg ? sat(-$signed({1'b0, shv})) : sat($signed({1'b0, shv}));

    // Operand select and sign of the running product.
    always_comb
    begin
        opa  = '0;
        opb  = '0;
        mneg = 1'b0;
        fneg = f_reg[W-1] != diff_reg[idx_reg][W];
        case (state_reg)
            S_SQ:   begin opa = AW'(dmag); opb = dmag; end
            S_SQRT: begin opa = sum_reg; end
            S_FMUL:
            begin
                opa  = AW'($unsigned(stiff_reg[W-1] ? -stiff_reg : stiff_reg));
                opb  = lmr_mag;
                mneg = stiff_reg[W-1] != lmr[W+1];
            end
            S_BREAK: begin opa = AW'(rest_reg); opb = {1'b0, brk_reg}; end
            S_TMUL:
            begin
                opa = AW'($unsigned(f_reg[W-1] ? -f_reg : f_reg));
                opb = dmag;
            end
            S_TDIV: begin opa = u_res; opb = len_reg; end
            S_DMA:
            begin
                opa  = AW'($unsigned(damp_reg[W-1] ? -damp_reg : damp_reg));
                opb  = (W+1)'($unsigned(va_reg[idx_reg][W-1] ? -va_reg[idx_reg]
                                                              : va_reg[idx_reg]));
                mneg = damp_reg[W-1] != va_reg[idx_reg][W-1];
            end
            S_DMB:
            begin
                opa  = AW'($unsigned(damp_reg[W-1] ? -damp_reg : damp_reg));
                opb  = (W+1)'($unsigned(vb_reg[idx_reg][W-1] ? -vb_reg[idx_reg]
                                                              : vb_reg[idx_reg]));
                mneg = damp_reg[W-1] != vb_reg[idx_reg][W-1];
            end
            default: ;
        endcase
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        sum_next   = sum_reg;
        len_next   = len_reg;
        f_next     = f_reg;
        term_next  = term_reg;
        da_next    = da_reg;
        over_next  = over_reg;
        pend_next  = pend_reg;
        fa_next    = fa_reg;
        fb_next    = fb_reg;
        ctl.start  = 1'b0;
        ctl.op     = OP_MUL;
        sa         = '0;
        sb         = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (pend_reg && out_ready)
                begin
                    pend_next = 1'b0;
                    if (idx_reg != AXIS_Z)
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = (len_reg == '0) ? S_DMA : S_TMUL;
                        term_next  = '0;
                    end
                end
                else if (in_valid && in_ready && axis == AXIS_Z)
                begin
                    idx_next   = AXIS_X;
                    sum_next   = '0;
                    state_next = S_SQ;
                end
            end
            S_SQ, S_SQRT, S_FMUL, S_BREAK, S_TMUL, S_TDIV, S_DMA, S_DMB:
            begin
                ctl.start = !go_reg;
                ctl.op    = (state_reg == S_SQRT) ? OP_SQRT :
                            (state_reg == S_TDIV) ? OP_DIV : OP_MUL;
                if (u_done)
                begin
                    case (state_reg)
                        S_SQ:
                        begin
                            sum_next = sum_reg + u_res;
                            if (idx_reg == AXIS_Z)
                                state_next = S_SQRT;
                            else
                                idx_next = idx_reg + 1'b1;
                        end
                        S_SQRT:
                        begin
                            len_next   = (W+1)'(u_res);
                            state_next = S_FMUL;
                        end
                        S_FMUL:
                        begin
                            f_next     = satv;
                            state_next = S_BREAK;
                        end
                        S_BREAK:
                        begin
                            over_next  = ({{(AW-W-1){1'b0}}, len_reg} << FRAC_BITS) > u_res;
                            idx_next   = AXIS_X;
                            term_next  = '0;
                            state_next = (len_reg == '0) ? S_DMA : S_TMUL;
                        end
                        S_TMUL: state_next = S_TDIV;
                        S_TDIV:
                        begin
                            term_next  = fneg ? -$signed({1'b0, u_res}) : $signed({1'b0, u_res});
                            state_next = S_DMA;
                        end
                        S_DMA:
                        begin
                            da_next    = (AW+1)'(satv);
                            state_next = S_DMB;
                        end
                        default:
                        begin
                            sa = term_reg + da_reg;
                            sb = -term_reg + (AW+1)'(satv);
                            fa_next    = sat(sa);
                            fb_next    = sat(sb);
                            pend_next  = 1'b1;
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pend_reg  <= 1'b0;
            go_reg    <= 1'b0;
            idx_reg   <= AXIS_X;
            len_reg   <= '0;
            over_reg  <= 1'b0;
            stiff_reg <= W'(64'd1 << FRAC_BITS);
            damp_reg  <= '0;
            brk_reg   <= W'(64'd2 << FRAC_BITS);
            rest_reg  <= '0;
            for (int i = 0; i < 3; i++)
            begin
                diff_reg[i] <= '0;
                va_reg[i]   <= '0;
                vb_reg[i]   <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            idx_reg   <= idx_next;
            len_reg   <= len_next;
            over_reg  <= over_next;
            // The unit is started once per operation; clear on done.
            go_reg    <= u_done ? 1'b0 : (go_reg | ctl.start);
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_STIFF: stiff_reg <= cfg_data;
                    REG_DAMP:  damp_reg  <= cfg_data;
                    REG_BREAK: brk_reg   <= cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && in_ready && axis != AXIS_NONE)
            begin
                diff_reg[axis] <= $signed({pos_a[W-1], pos_a}) - $signed({pos_b[W-1], pos_b});
                va_reg[axis]   <= vel_a;
                vb_reg[axis]   <= vel_b;
                if (axis == AXIS_Z)
                    rest_reg <= rest_length;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg  <= sum_next;
        f_reg    <= f_next;
        term_reg <= term_next;
        da_reg   <= da_next;
        fa_reg   <= fa_next;
        fb_reg   <= fb_next;
    end
endmodule

### rtl/dsf_serial_unit.sv
// ----------------------------------------------------------------------------
// dsf_serial_unit
// Bit-serial multiplier, square root and divider sharing one datapath.
// ----------------------------------------------------------------------------
module dsf_serial_unit
    import dsf_pkg::*;
#(
    parameter int W = 32
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  dsf_ctl_t       ctl,
    input  logic [2*W+1:0] opa,
    input  logic [W:0]     opb,
    output logic           done,
    output logic [2*W+1:0] res
);
    localparam int AW = 2 * W + 2;
    localparam int CW = $clog2(AW + 1);

    logic [AW-1:0] acc_reg, acc_next;
    logic [AW-1:0] sh_reg, sh_next;
    logic [AW:0]   rem_reg, rem_next;
    logic [W:0]    b_reg, b_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    dsf_op_t       op_reg, op_next;
    logic          busy_reg, busy_next;
    logic [AW:0]   trial;
    logic [AW:0]   rsh;

    assign res  = acc_reg;
    assign done = busy_reg && (cnt_reg == '0);

    always_comb
    begin
        acc_next  = acc_reg;
        sh_next   = sh_reg;
        rem_next  = rem_reg;
        b_next    = b_reg;
        cnt_next  = cnt_reg;
        op_next   = op_reg;
        busy_next = busy_reg;
        trial     = '0;
        rsh       = '0;
        if (ctl.start)
        begin
            busy_next = 1'b1;
            op_next   = ctl.op;
            sh_next   = opa;
            b_next    = opb;
            acc_next  = '0;
            rem_next  = '0;
            case (ctl.op)
                OP_MUL:  cnt_next = CW'(W + 1);
                OP_SQRT: cnt_next = CW'(AW / 2);
                default: cnt_next = CW'(AW);
            endcase
        end
        else if (busy_reg && cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            case (op_reg)
                // Shift-add: one multiplier bit per cycle, MSB first.
                OP_MUL:
                begin
                    acc_next = (acc_reg << 1) +
                               (b_reg[W] ? sh_reg : '0);
                    b_next   = b_reg << 1;
                end
                // Restoring square root, two radicand bits per cycle.
                OP_SQRT:
                begin
                    rsh   = {rem_reg[AW-2:0], sh_reg[AW-1:AW-2]};
                    trial = {acc_reg[AW-2:0], 2'b01};
                    sh_next = sh_reg << 2;
                    if (rsh >= trial)
                    begin
                        rem_next = rsh - trial;
                        acc_next = {acc_reg[AW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next = rsh;
                        acc_next = {acc_reg[AW-2:0], 1'b0};
                    end
                end
                // Restoring division, one quotient bit per cycle.
                default:
                begin
                    rsh     = {rem_reg[AW-1:0], sh_reg[AW-1]};
                    sh_next = sh_reg << 1;
                    if (rsh >= {{(AW-W){1'b0}}, b_reg})
                    begin
                        rem_next = rsh - {{(AW-W){1'b0}}, b_reg};
                        acc_next = {acc_reg[AW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next = rsh;
                        acc_next = {acc_reg[AW-2:0], 1'b0};
                    end
                end
            endcase
        end
        else if (busy_reg)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= OP_MUL;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            op_reg   <= op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        sh_reg  <= sh_next;
        rem_reg <= rem_next;
        b_reg   <= b_next;
    end
endmodule

### rtl/dsf_checker.sv
// ----------------------------------------------------------------------------
// dsf_checker
// Port-level checks of the damped spring force block.
// ----------------------------------------------------------------------------
`include "damped_spring_force_breaker_assert.svh"
module dsf_checker
    import dsf_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] out_axis,
    input logic       last_of_run,
    input logic       zero_length,
    input logic       overstretched
)
;
    // No input beat is taken while a result beat waits.
    `DSF_ASSERT_IMP(a_no_in_when_out, clk, rst_n, out_valid, !in_ready)
    // The last flag marks the z result only.
    `DSF_ASSERT_IMP(a_last_z, clk, rst_n, out_valid, last_of_run == (out_axis == AXIS_Z))
    // A zero length never reports overstretch.
    `DSF_ASSERT_IMP(a_zero_over, clk, rst_n, out_valid && zero_length, !overstretched)
    // A stalled result beat holds.
    `DSF_ASSERT_NXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_axis))
endmodule

bind damped_spring_force_breaker dsf_checker u_dsf_checker
(
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .out_axis(out_axis),
    .last_of_run(last_of_run), .zero_length(zero_length),
    .overstretched(overstretched)
);

### bench/tb_damped_spring_force_breaker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_damped_spring_force_breaker
// Drives spring axis beats and register writes into the force block, predicts
// every force beat with a wide-integer model of the spring, and compares each
// output beat field by field. Sender and receiver idle at random in phases.
// ----------------------------------------------------------------------------
module tb_damped_spring_force_breaker;
    import dsf_pkg::*;

    localparam int VW = 32;
    localparam int FB = 16;
    localparam int SETTLE_CYCLES = 40;
    localparam longint CYCLE_LIMIT = 900000;

    typedef struct {
        logic [1:0]    ax;
        logic [VW-1:0] fa;
        logic [VW-1:0] fb;
        logic          over;
        logic          zero;
        logic          last;
    } force_beat_t;

    logic clk;
    logic rst_n;
    logic cfg_valid;
    logic cfg_ready;
    logic [1:0] cfg_index;
    logic [VW-1:0] cfg_data;
    logic in_valid;
    logic in_ready;
    logic [1:0] axis;
    logic signed [VW-1:0] pos_a;
    logic signed [VW-1:0] pos_b;
    logic signed [VW-1:0] vel_a;
    logic signed [VW-1:0] vel_b;
    logic [VW-1:0] rest_length;
    logic out_valid;
    logic out_ready;
    logic [1:0] out_axis;
    logic signed [VW-1:0] force_a;
    logic signed [VW-1:0] force_b;
    logic overstretched;
    logic zero_length;
    logic last_of_run;

    // Spring model state and register copies.
    longint axis_diff_m[3];
    longint axis_vel_a_m[3];
    longint axis_vel_b_m[3];
    longint stiffness_m;
    longint damping_m;
    longint break_ratio_m;

    force_beat_t expected_forces[$];
    int error_count;
    int sender_idle_pct;
    int receiver_idle_pct;
    longint cycle_count;

    damped_spring_force_breaker #(
        .VALUE_WIDTH(VW),
        .FRAC_BITS(FB)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .axis(axis),
        .pos_a(pos_a),
        .pos_b(pos_b),
        .vel_a(vel_a),
        .vel_b(vel_b),
        .rest_length(rest_length),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_axis(out_axis),
        .force_a(force_a),
        .force_b(force_b),
        .overstretched(overstretched),
        .zero_length(zero_length),
        .last_of_run(last_of_run)
    );

    // Clock with a 12 ns period.
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_damped_spring_force_breaker: done, errors");
            $finish;
        end
    end

    function automatic logic [127:0] mag128(longint x);
        logic [63:0] m;
        m = (x < 0) ? -x : x;
        return {64'd0, m};
    endfunction

    // Product shifted down by the fraction bits, truncated toward zero, saturated.
    function automatic longint fixed_mul(longint a, longint b);
        logic [127:0] p;
        logic [127:0] cap;
        logic neg;
        neg = (a < 0) != (b < 0);
        p = (mag128(a) * mag128(b)) >> FB;
        cap = neg ? (128'd1 << (VW - 1)) : ((128'd1 << (VW - 1)) - 1);
        if (p > cap)
            p = cap;
        return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
    endfunction

    function automatic longint clamp_value(longint x);
        longint hi;
        hi = (longint'(1) << (VW - 1)) - 1;
        if (x > hi)
            return hi;
        if (x < -hi - 1)
            return -hi - 1;
        return x;
    endfunction

    // Floor of the square root, one result bit per step.
    function automatic logic [63:0] int_sqrt(logic [127:0] n);
        logic [127:0] rem;
        logic [127:0] res;
        logic [127:0] trial;
        rem = '0;
        res = '0;
        for (int i = 63; i >= 0; i--)
        begin
            trial = (res << 2) | 128'd1;
            rem = (rem << 2) | ((n >> (2 * i)) & 128'd3);
            if (rem >= trial)
            begin
                rem = rem - trial;
                res = (res << 1) | 128'd1;
            end
            else
                res = res << 1;
        end
        return res[63:0];
    endfunction

    function automatic longint sext_value(logic [VW-1:0] v);
        return longint'($signed(v));
    endfunction

    // Store one axis beat and, on z, queue the three force beats it causes.
    task automatic predict_spring_forces(logic [1:0] ax, logic [VW-1:0] pa, logic [VW-1:0] pb,
                                         logic [VW-1:0] va, logic [VW-1:0] vb,
                                         logic [VW-1:0] rest);
        logic [127:0] sum;
        logic [63:0] len;
        logic over;
        logic zero;
        longint f;
        longint term;
        logic [127:0] q;
        force_beat_t beat;
        if (ax == AXIS_NONE)
            return;
        axis_diff_m[ax] = sext_value(pa) - sext_value(pb);
        axis_vel_a_m[ax] = sext_value(va);
        axis_vel_b_m[ax] = sext_value(vb);
        if (ax != AXIS_Z)
            return;
        sum = '0;
        for (int i = 0; i < 3; i++)
            sum = sum + mag128(axis_diff_m[i]) * mag128(axis_diff_m[i]);
        len = int_sqrt(sum);
        zero = (len == 0);
        over = ({64'd0, len} << FB) > ({96'd0, rest} * 128'(break_ratio_m));
        f = fixed_mul(stiffness_m, longint'(len) - longint'({32'd0, rest}));
        for (int i = 0; i < 3; i++)
        begin
            term = 0;
            if (!zero)
            begin
                q = (mag128(f) * mag128(axis_diff_m[i])) / {64'd0, len};
                term = ((f < 0) != (axis_diff_m[i] < 0)) ? -longint'(q[63:0])
                                                          : longint'(q[63:0]);
            end
            beat.ax = 2'(i);
            beat.fa = VW'(clamp_value(term + fixed_mul(damping_m, axis_vel_a_m[i])));
            beat.fb = VW'(clamp_value(-term + fixed_mul(damping_m, axis_vel_b_m[i])));
            beat.over = over;
            beat.zero = zero;
            beat.last = (i == 2);
            expected_forces.insert(expected_forces.size(), beat);
        end
    endtask

    task automatic check_field(string name, longint exp_v, longint act_v);
        if (exp_v != act_v)
        begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            error_count++;
        end
    endtask

    // Compare every accepted force beat with the oldest expectation.
    always @(posedge clk)
    begin
        force_beat_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_forces.size() == 0)
            begin
                $error("unexpected force beat on axis %0d", out_axis);
                error_count++;
            end
            else
            begin
                e = expected_forces.pop_front();
                check_field("out_axis", e.ax, out_axis);
                check_field("force_a", e.fa, $unsigned(force_a));
                check_field("force_b", e.fb, $unsigned(force_b));
                check_field("overstretched", e.over, overstretched);
                check_field("zero_length", e.zero, zero_length);
                check_field("last_of_run", e.last, last_of_run);
            end
        end
    end

    // Receiver stalls.
    always @(negedge clk)
    begin
        out_ready = rst_n && ($urandom_range(99) >= receiver_idle_pct);
    end

    // Send one axis beat, at random after a gap of random length.
    task automatic send_axis(logic [1:0] ax, logic [VW-1:0] pa, logic [VW-1:0] pb,
                             logic [VW-1:0] va, logic [VW-1:0] vb, logic [VW-1:0] rest);
        if ($urandom_range(99) < sender_idle_pct)
        begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat ($urandom_range(3))
                @(negedge clk);
        end
        else
            @(negedge clk);
        in_valid = 1'b1;
        axis = ax;
        pos_a = pa;
        pos_b = pb;
        vel_a = va;
        vel_b = vb;
        rest_length = rest;
        do
            @(posedge clk);
        while (!in_ready);
        predict_spring_forces(ax, pa, pb, va, vb, rest);
    endtask

    // Wait until every force beat has arrived and the block has settled.
    task automatic drain_outputs();
        @(negedge clk);
        in_valid = 1'b0;
        while (expected_forces.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_register(logic [1:0] idx, logic [VW-1:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_STIFF: stiffness_m = sext_value(data);
            REG_DAMP:  damping_m = sext_value(data);
            REG_BREAK: break_ratio_m = longint'({32'd0, data});
            default: ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_spring_registers(logic [VW-1:0] k, logic [VW-1:0] d,
                                        logic [VW-1:0] br);
        drain_outputs();
        write_register(REG_STIFF, k);
        write_register(REG_DAMP, d);
        write_register(REG_BREAK, br);
    endtask

    // Moderate values so forces do not always saturate, mixed with extremes and full-range values.
    function automatic logic [VW-1:0] random_value();
        case ($urandom_range(7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return '0;
            3, 4, 5: return ($urandom_range(1) ? -1 : 1) * int'($urandom_range(32'h00ff_ffff));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [VW-1:0] random_rest();
        case ($urandom_range(5))
            0: return '0;
            1: return 32'hffff_ffff;
            2, 3: return $urandom_range(32'h01ff_ffff);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_spring(logic [VW-1:0] rest);
        send_axis(AXIS_X, random_value(), random_value(), random_value(), random_value(), 0);
        send_axis(AXIS_Y, random_value(), random_value(), random_value(), random_value(), 0);
        send_axis(AXIS_Z, random_value(), random_value(), random_value(), random_value(), rest);
    endtask

    // Reset defaults, ignored code, zero length, missing axes and field extremes.
    task automatic test_directed();
        send_axis(AXIS_NONE, 32'hffff_ffff, 0, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        send_axis(AXIS_Z, 0, 0, 0, 0, 32'h0001_0000);
        send_axis(AXIS_Z, 32'h0003_0000, 0, 32'h0001_0000, 32'hffff_0000, 32'h0001_0000);
        send_axis(AXIS_X, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 0);
        send_axis(AXIS_Y, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 0);
        send_axis(AXIS_Z, 32'h7fff_ffff, 32'h8000_0000, 0, 0, 0);
        send_axis(AXIS_Z, 32'h0001_0000, 32'h0001_0000, 0, 0, 32'hffff_ffff);
        send_axis(AXIS_X, 32'h0004_0000, 32'h0004_0000, 0, 0, 0);
        send_axis(AXIS_Y, 32'h0004_0000, 32'h0004_0000, 0, 0, 0);
        send_axis(AXIS_Z, 32'h1234_5678, 32'h1234_5678, 0, 0, 32'h0002_0000);
        set_spring_registers(32'h0002_8000, 32'h0000_8000, 32'h0001_8000);
        send_axis(AXIS_Z, 5, 5, 32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000);
        send_axis(AXIS_X, 32'h0003_0000, 0, 32'h0001_0000, 32'h0002_0000, 0);
        send_axis(AXIS_Y, 32'h0004_0000, 0, 32'hffff_0000, 32'h0001_0000, 0);
        send_axis(AXIS_Z, 0, 0, 0, 0, 32'h0002_0000);
        send_axis(AXIS_Z, 0, 0, 0, 0, 32'h0008_0000);
    endtask

    task automatic test_register_extremes();
        set_spring_registers(32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000);
        repeat (4)
            send_spring(random_rest());
        set_spring_registers(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff);
        repeat (4)
            send_spring(random_rest());
    endtask

    // Well-formed springs with random content, plus partial and ignored beats.
    task automatic test_random_springs(int springs);
        for (int s = 0; s < springs; s++)
        begin
            if (s % 10 == 0)
                set_spring_registers(random_value(), random_value(),
                                     $urandom_range(1) ? $urandom_range(32'h0004_0000)
                                                       : $urandom);
            if ($urandom_range(9) < 8)
                send_spring(random_rest());
            else
                send_axis(2'($urandom_range(3)), random_value(), random_value(),
                          random_value(), random_value(), random_rest());
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_STIFF;
        cfg_data = '0;
        in_valid = 1'b0;
        axis = AXIS_X;
        pos_a = '0;
        pos_b = '0;
        vel_a = '0;
        vel_b = '0;
        rest_length = '0;
        out_ready = 1'b0;
        error_count = 0;
        cycle_count = 0;
        stiffness_m = longint'(1) << FB;
        damping_m = 0;
        break_ratio_m = longint'(2) << FB;
        for (int i = 0; i < 3; i++)
        begin
            axis_diff_m[i] = 0;
            axis_vel_a_m[i] = 0;
            axis_vel_b_m[i] = 0;
        end
        sender_idle_pct = 16;
        receiver_idle_pct = 52;
        repeat (5)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_register_extremes();
        test_random_springs(28);
        sender_idle_pct = 52;
        receiver_idle_pct = 16;
        test_random_springs(28);
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        test_random_springs(28);
        drain_outputs();

        if (error_count == 0)
            $display("tb_damped_spring_force_breaker: done, clean");
        else
            $display("tb_damped_spring_force_breaker: done, errors");
        $finish;
    end
endmodule

### filelist.f
+incdir+rtl
rtl/dsf_pkg.sv
rtl/dsf_serial_unit.sv
rtl/damped_spring_force_breaker.sv
rtl/dsf_checker.sv
bench/tb_damped_spring_force_breaker.sv
